// ----- src/assert_macros.svh -----
// Assertion macros shared by the calendar converter RTL.
// Depends on nothing; the assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JDC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define JDC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define JDC_ASSERT(lbl, clk, rstn, prop)
`define JDC_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- src/jdc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup functions of the calendar converter.
// Depends on nothing; every module of the block imports it.
package jdc_pkg;

    localparam int NSTG   = 7;
    localparam int JD_W   = 23;
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int ORD_W  = 9;
    localparam int WD_W   = 3;

    localparam logic CMD_TO_JD   = 1'b0;
    localparam logic CMD_TO_DATE = 1'b1;

    localparam logic [JD_W-1:0]   JD_FIRST      = 23'd2361222;
    localparam logic [JD_W-1:0]   JD_LAST       = 23'd5373484;
    localparam logic [JD_W-1:0]   JD_EPOCH      = 23'd1721119;
    localparam logic [YEAR_W-1:0] YEAR_FIRST    = 14'd1752;
    localparam logic [YEAR_W-1:0] YEAR_LAST     = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_BASE     = 14'd1900;
    localparam logic [YEAR_W-1:0] TWO_DIGIT_MAX = 14'd99;
    localparam logic [MON_W-1:0]  MON_FIRST     = 4'd9;
    localparam logic [DAY_W-1:0]  DAY_FIRST     = 5'd14;

    // Division of a year by 100: multiply by 5243 and drop 19 bits.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  CENTURY      = 7'd100;

    // Days in 400 years and in 4 years, with their scaled reciprocals.
    localparam logic [17:0] DAYS_400Y     = 18'd146097;
    localparam logic [10:0] DAYS_4Y       = 11'd1461;
    localparam logic [14:0] RECIP_400Y    = 15'd29398;
    localparam int          RECIP_400Y_SH = 32;
    localparam logic [17:0] RECIP_4Y      = 18'd183734;
    localparam int          RECIP_4Y_SH   = 28;

    typedef struct packed {
        logic [NSTG-1:0] ce;
    } jdc_ctrl_t;

    typedef struct packed {
        logic              ok;
        logic [JD_W-1:0]   jd;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic              leap;
    } jdc_res_t;

    typedef struct packed {
        logic              ok;
        logic [JD_W-1:0]   jd;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic              leap;
        logic [WD_W-1:0]   weekday;
        logic [ORD_W-1:0]  ordinal;
        logic [DAY_W-1:0]  mlen;
    } jdc_out_t;

    // First day offset of each month in a year that starts in March.
    function automatic logic [8:0] month_start(input logic [3:0] mi);
        logic [8:0] r;
        unique case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Days before the first of a month in a common year.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  r = 5'd30;
            4'd2:                                      r = leap ? 5'd29 : 5'd28;
            default:                                   r = 5'd0;
        endcase
        return r;
    endfunction

    // Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [JD_W-1:0] v);
        logic [23:0] w;
        logic [5:0]  s;
        logic [3:0]  s2;
        logic [3:0]  r;
        w = {1'b0, v};
        s = 6'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 6'(w[3*i +: 3]);
        end
        s2 = 4'(s[5:3]) + 4'(s[2:0]);
        if (s2 >= 4'd14) begin
            r = s2 - 4'd14;
        end else if (s2 >= 4'd7) begin
            r = s2 - 4'd7;
        end else begin
            r = s2;
        end
        return r[2:0];
    endfunction

endpackage

// ----- src/jdc_pipe_ctrl.sv -----
`timescale 1ns / 1ps
// Valid and ready chain of the converter pipeline, with the command bit per stage.
// Depends on jdc_pkg.
module jdc_pipe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              cmd_last,
    output jdc_pkg::jdc_ctrl_t ctrl
);
    import jdc_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic [NSTG-2:0] cmd_reg;

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) begin
            cmd_reg[0] <= in_cmd;
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (rdy[k]) begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign cmd_last  = cmd_reg[NSTG-2];
    assign ctrl.ce   = rdy;

endmodule

// ----- src/jdc_date2jd.sv -----
`timescale 1ns / 1ps
// Date to day number path: six register stages from the input fields.
// Depends on jdc_pkg.
module jdc_date2jd (
    input  logic                             clk,
    input  jdc_pkg::jdc_ctrl_t               ctrl,
    input  logic [jdc_pkg::YEAR_W-1:0]       year_in,
    input  logic [jdc_pkg::MON_W-1:0]        month_in,
    input  logic [jdc_pkg::DAY_W-1:0]        day_in,
    output jdc_pkg::jdc_res_t                res
);
    import jdc_pkg::*;

    // Stage 1: two-digit years folded into the 1900s.
    logic [YEAR_W-1:0] yn1_reg;
    logic [YEAR_W-1:0] yn1_next;
    logic [MON_W-1:0]  mon1_reg;
    logic [DAY_W-1:0]  day1_reg;

    // Stage 2: range checks and the century products.
    logic [26:0]       pyn2_reg;
    logic [26:0]       pys2_reg;
    logic [26:0]       pyn2_next;
    logic [26:0]       pys2_next;
    logic [YEAR_W-1:0] ys1;
    logic [MON_W-1:0]  mi1;
    logic              pre_ok2_reg;
    logic              pre_ok2_next;
    logic [YEAR_W-1:0] yn2_reg;
    logic [YEAR_W-1:0] ys2_reg;
    logic [MON_W-1:0]  mi2_reg;
    logic [MON_W-1:0]  mon2_reg;
    logic [DAY_W-1:0]  day2_reg;

    // Stage 3: leap year, month length check, year in century.
    logic [7:0]        cen_y2;
    logic [7:0]        cen_s2;
    logic              leap3_next;
    logic              ok3_next;
    logic [6:0]        yr3_next;
    logic [7:0]        cen3_reg;
    logic [6:0]        yr3_reg;
    logic              leap3_reg;
    logic              ok3_reg;
    logic [YEAR_W-1:0] yn3_reg;
    logic [MON_W-1:0]  mi3_reg;
    logic [MON_W-1:0]  mon3_reg;
    logic [DAY_W-1:0]  day3_reg;

    // Stage 4: the three day count terms.
    logic [25:0]       t1_full;
    logic [17:0]       t2_full;
    logic [JD_W-1:0]   t1_reg;
    logic [15:0]       t2_reg;
    logic [8:0]        t3_reg;
    logic              leap4_reg;
    logic              ok4_reg;
    logic [YEAR_W-1:0] yn4_reg;
    logic [MON_W-1:0]  mon4_reg;
    logic [DAY_W-1:0]  day4_reg;

    // Stage 5: partial sum.
    logic [JD_W-1:0]   part5_reg;
    logic [8:0]        t3_5_reg;
    logic              leap5_reg;
    logic              ok5_reg;
    logic [YEAR_W-1:0] yn5_reg;
    logic [MON_W-1:0]  mon5_reg;
    logic [DAY_W-1:0]  day5_reg;

    // Stage 6: finished day number.
    jdc_res_t          res6_reg;

    assign yn1_next = (year_in <= TWO_DIGIT_MAX) ? year_in + YEAR_BASE : year_in;

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[0]) begin
            yn1_reg  <= yn1_next;
            mon1_reg <= month_in;
            day1_reg <= day_in;
        end
    end

    // January and February count as months of the previous year.
    always_comb
    begin
        if (mon1_reg > 4'd2) begin
            ys1 = yn1_reg;
            mi1 = mon1_reg - 4'd3;
        end else begin
            ys1 = yn1_reg - 14'd1;
            mi1 = mon1_reg + 4'd9;
        end
        pyn2_next    = 27'(yn1_reg) * 27'(DIV100_MUL);
        pys2_next    = 27'(ys1) * 27'(DIV100_MUL);
        pre_ok2_next = (yn1_reg >= YEAR_FIRST) && (yn1_reg <= YEAR_LAST)
                       && !((yn1_reg == YEAR_FIRST)
                            && ((mon1_reg < MON_FIRST)
                                || ((mon1_reg == MON_FIRST) && (day1_reg < DAY_FIRST))))
                       && (mon1_reg >= 4'd1) && (mon1_reg <= 4'd12)
                       && (day1_reg != 5'd0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[1]) begin
            pyn2_reg    <= pyn2_next;
            pys2_reg    <= pys2_next;
            pre_ok2_reg <= pre_ok2_next;
            yn2_reg     <= yn1_reg;
            ys2_reg     <= ys1;
            mi2_reg     <= mi1;
            mon2_reg    <= mon1_reg;
            day2_reg    <= day1_reg;
        end
    end

    always_comb
    begin
        cen_y2     = pyn2_reg[DIV100_SHIFT +: 8];
        cen_s2     = pys2_reg[DIV100_SHIFT +: 8];
        leap3_next = (yn2_reg[1:0] == 2'b00)
                     && ((yn2_reg != 14'(cen_y2) * 14'(CENTURY)) || (cen_y2[1:0] == 2'b00));
        ok3_next   = pre_ok2_reg && (day2_reg <= month_len(mon2_reg, leap3_next));
        yr3_next   = 7'(ys2_reg - 14'(cen_s2) * 14'(CENTURY));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[2]) begin
            cen3_reg  <= cen_s2;
            yr3_reg   <= yr3_next;
            leap3_reg <= leap3_next;
            ok3_reg   <= ok3_next;
            yn3_reg   <= yn2_reg;
            mi3_reg   <= mi2_reg;
            mon3_reg  <= mon2_reg;
            day3_reg  <= day2_reg;
        end
    end

    assign t1_full = 26'(cen3_reg) * 26'(DAYS_400Y);
    assign t2_full = 18'(yr3_reg) * 18'(DAYS_4Y);

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[3]) begin
            t1_reg    <= t1_full[24:2];
            t2_reg    <= t2_full[17:2];
            t3_reg    <= 9'(day3_reg) + month_start(mi3_reg);
            leap4_reg <= leap3_reg;
            ok4_reg   <= ok3_reg;
            yn4_reg   <= yn3_reg;
            mon4_reg  <= mon3_reg;
            day4_reg  <= day3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[4]) begin
            part5_reg <= t1_reg + 23'(t2_reg);
            t3_5_reg  <= t3_reg;
            leap5_reg <= leap4_reg;
            ok5_reg   <= ok4_reg;
            yn5_reg   <= yn4_reg;
            mon5_reg  <= mon4_reg;
            day5_reg  <= day4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[5]) begin
            res6_reg.ok    <= ok5_reg;
            res6_reg.jd    <= JD_EPOCH + part5_reg + 23'(t3_5_reg);
            res6_reg.year  <= yn5_reg;
            res6_reg.month <= mon5_reg;
            res6_reg.day   <= day5_reg;
            res6_reg.leap  <= leap5_reg;
        end
    end

    assign res = res6_reg;

endmodule

// ----- src/jdc_jd2date.sv -----
`timescale 1ns / 1ps
// Day number to date path: six register stages, two reciprocal divisions.
// Depends on jdc_pkg.
module jdc_jd2date (
    input  logic                         clk,
    input  jdc_pkg::jdc_ctrl_t           ctrl,
    input  logic [jdc_pkg::JD_W-1:0]     day_number_in,
    output jdc_pkg::jdc_res_t            res
);
    import jdc_pkg::*;

    logic              ok1_reg;
    logic [21:0]       j1_reg;
    logic [JD_W-1:0]   jd1_reg;

    logic [23:0]       a1;
    logic [23:0]       a2_reg;
    logic [38:0]       prod2_reg;
    logic              ok2_reg;
    logic [JD_W-1:0]   jd2_reg;

    logic [6:0]        q3;
    logic [24:0]       rem3;
    logic              fix3;
    logic [6:0]        y1_3_reg;
    logic [17:0]       r1_3_reg;
    logic              ok3_reg;
    logic [JD_W-1:0]   jd3_reg;

    logic [17:0]       b4;
    logic [17:0]       b4_reg;
    logic [35:0]       prod4_reg;
    logic [6:0]        y1_4_reg;
    logic              ok4_reg;
    logic [JD_W-1:0]   jd4_reg;

    logic [6:0]        q5;
    logic [17:0]       rem5;
    logic              fix5;
    logic [10:0]       r2_5;
    logic [6:0]        j2_5_reg;
    logic [8:0]        x3_5_reg;
    logic [6:0]        y1_5_reg;
    logic              ok5_reg;
    logic [JD_W-1:0]   jd5_reg;

    logic [3:0]        mi6;
    logic              hi6;
    logic [6:0]        yy6;
    logic [6:0]        cen6;
    jdc_res_t          res6_next;
    jdc_res_t          res6_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[0]) begin
            ok1_reg <= (day_number_in >= JD_FIRST) && (day_number_in <= JD_LAST);
            j1_reg  <= 22'(day_number_in - JD_EPOCH);
            jd1_reg <= day_number_in;
        end
    end

    assign a1 = {j1_reg, 2'b00} - 24'd1;

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[1]) begin
            a2_reg    <= a1;
            prod2_reg <= 39'(a1) * 39'(RECIP_400Y);
            ok2_reg   <= ok1_reg;
            jd2_reg   <= jd1_reg;
        end
    end

    // The reciprocal estimate is at most one low; one compare fixes it.
    always_comb
    begin
        q3   = prod2_reg[RECIP_400Y_SH +: 7];
        rem3 = 25'(a2_reg) - 25'(q3) * 25'(DAYS_400Y);
        fix3 = rem3 >= 25'(DAYS_400Y);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[2]) begin
            y1_3_reg <= q3 + 7'(fix3);
            r1_3_reg <= fix3 ? 18'(rem3 - 25'(DAYS_400Y)) : 18'(rem3);
            ok3_reg  <= ok2_reg;
            jd3_reg  <= jd2_reg;
        end
    end

    assign b4 = {r1_3_reg[17:2], 2'b11};

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[3]) begin
            b4_reg    <= b4;
            prod4_reg <= 36'(b4) * 36'(RECIP_4Y);
            y1_4_reg  <= y1_3_reg;
            ok4_reg   <= ok3_reg;
            jd4_reg   <= jd3_reg;
        end
    end

    always_comb
    begin
        q5   = prod4_reg[RECIP_4Y_SH +: 7];
        rem5 = b4_reg - 18'(q5) * 18'(DAYS_4Y);
        fix5 = rem5 >= 18'(DAYS_4Y);
        r2_5 = fix5 ? 11'(rem5 - 18'(DAYS_4Y)) : 11'(rem5);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[4]) begin
            j2_5_reg <= q5 + 7'(fix5);
            x3_5_reg <= 9'(r2_5[10:2]) + 9'd1;
            y1_5_reg <= y1_4_reg;
            ok5_reg  <= ok4_reg;
            jd5_reg  <= jd4_reg;
        end
    end

    // Month of a March-based year from the day in that year; January and
    // February move the year on by one.
    always_comb
    begin
        mi6 = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (x3_5_reg > month_start(4'(k))) begin
                mi6 = 4'(k);
            end
        end
        hi6  = mi6 >= 4'd10;
        yy6  = j2_5_reg + 7'(hi6);
        cen6 = (yy6 == CENTURY) ? y1_5_reg + 7'd1 : y1_5_reg;
        res6_next.ok    = ok5_reg;
        res6_next.jd    = jd5_reg;
        res6_next.year  = 14'(y1_5_reg) * 14'(CENTURY) + 14'(yy6);
        res6_next.month = hi6 ? mi6 - 4'd9 : mi6 + 4'd3;
        res6_next.day   = 5'(x3_5_reg - month_start(mi6));
        res6_next.leap  = (yy6[1:0] == 2'b00)
                          && (((yy6 != 7'd0) && (yy6 != CENTURY)) || (cen6[1:0] == 2'b00));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[5]) begin
            res6_reg <= res6_next;
        end
    end

    assign res = res6_reg;

endmodule

// ----- src/jdc_finish.sv -----
`timescale 1ns / 1ps
// Output stage: weekday, day of year and month length, zeroed when invalid.
// Depends on jdc_pkg.
module jdc_finish (
    input  logic                 clk,
    input  jdc_pkg::jdc_ctrl_t   ctrl,
    input  jdc_pkg::jdc_res_t    res,
    output jdc_pkg::jdc_out_t    out
);
    import jdc_pkg::*;

    jdc_out_t out_reg;
    jdc_out_t out_next;

    always_comb
    begin
        out_next = '0;
        if (res.ok) begin
            out_next.ok      = 1'b1;
            out_next.jd      = res.jd;
            out_next.year    = res.year;
            out_next.month   = res.month;
            out_next.day     = res.day;
            out_next.leap    = res.leap;
            out_next.weekday = mod7(res.jd) + 3'd1;
            out_next.ordinal = days_before(res.month) + 9'(res.day)
                               + 9'(res.leap && (res.month > 4'd2));
            out_next.mlen    = month_len(res.month, res.leap);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce[NSTG-1]) begin
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

// ----- src/julian_day_calendar_converter_core.sv -----
`timescale 1ns / 1ps
// Gregorian date / Julian day number converter, seven-stage pipeline.
// Depends on jdc_pkg, jdc_pipe_ctrl, jdc_date2jd, jdc_jd2date, jdc_finish
// and assert_macros.svh.
//
// Usage: each item on the slave channel carries a command in s_tuser. Command
// 0 converts year, month and day to a Julian day number; command 1 converts a
// day number back to a date. Every item gives exactly one result item on the
// master channel, in order. m_tuser is high when the date or day number lies
// between 1752-09-14 and 9999-12-31; otherwise every result field is zero.
// An item lands in the first stage register at the accepting edge and moves
// through the stage registers in order until its result reaches the output
// register. Throughput is one item per cycle while the receiver keeps up; the
// two constant divisions (by 146097 and by 1461) are reciprocal multiplies
// with a one-step correction, each over two stages, and they set the depth.
// Every stage has its own valid bit and loads when it is empty or its content
// moves on, so a stalled receiver only backs up the pipeline: s_tready falls
// once all seven stages hold items, and bubbles fill while the output waits.
// Reset clears the valid bits; no item is in flight afterwards.
`include "assert_macros.svh"
module julian_day_calendar_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] year_in, [17:14] month_in, [22:18] day_in,
    // [45:23] day_number_in, [47:46] zero
    input  logic [47:0] s_tdata,
    // [0] cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [22:0] day_number_out, [36:23] year_out, [40:37] month_out,
    // [45:41] day_out, [46] is_leap, [49:47] weekday, [58:50] ordinal_day,
    // [63:59] month_length
    output logic [63:0] m_tdata,
    // [0] valid_res
    output logic        m_tuser
);
    import jdc_pkg::*;

    jdc_ctrl_t ctrl;
    logic      cmd_last;
    jdc_res_t  res_date;
    jdc_res_t  res_jd;
    jdc_res_t  res_sel;
    jdc_out_t  out;
    logic      res_fields_ok;

    jdc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .cmd_last  (cmd_last),
        .ctrl      (ctrl)
    );

    // Both paths see every item; the command picks one result in stage six.
    jdc_date2jd u_date2jd (
        .clk      (clk),
        .ctrl     (ctrl),
        .year_in  (s_tdata[13:0]),
        .month_in (s_tdata[17:14]),
        .day_in   (s_tdata[22:18]),
        .res      (res_date)
    );

    jdc_jd2date u_jd2date (
        .clk           (clk),
        .ctrl          (ctrl),
        .day_number_in (s_tdata[45:23]),
        .res           (res_jd)
    );

    assign res_sel = (cmd_last == CMD_TO_DATE) ? res_jd : res_date;

    jdc_finish u_finish (
        .clk  (clk),
        .ctrl (ctrl),
        .res  (res_sel),
        .out  (out)
    );

    assign m_tuser = out.ok;
    assign m_tdata = {out.mlen, out.ordinal, out.weekday, out.leap, out.day,
                      out.month, out.year, out.jd};

    // A valid result is a real date inside the supported span.
    assign res_fields_ok = (out.month != 4'd0) && (out.month <= 4'd12)
                           && (out.weekday != 3'd0) && (out.ordinal != 9'd0)
                           && (out.jd >= JD_FIRST) && (out.jd <= JD_LAST);

    // An invalid item leaves nothing behind in the payload.
    `JDC_ASSERT(a_invalid_zero, clk, rst_n, (m_tvalid && !m_tuser) |-> (m_tdata == 64'd0))

    `JDC_ASSERT(a_valid_fields, clk, rst_n, (m_tvalid && m_tuser) |-> res_fields_ok)

    // Input backpressure only comes from a full pipeline behind a stalled output.
    `JDC_ASSERT(a_stall_source, clk, rst_n, !s_tready |-> (m_tvalid && !m_tready))

endmodule

// ----- tb/jdc_conversion_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the calendar converter: watches both stream channels,
// predicts every result item from the accepted items and compares in order.
// Depends on jdc_pkg for the result layout and the calendar constants.
module jdc_conversion_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    output int          mismatches,
    output int          pending
);
    import jdc_pkg::*;

    // Both counters are two-state and start at zero.
    jdc_out_t expected_conversions[$];

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        if (m == 2) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        if (m >= 1 && m <= 12) begin
            return 31;
        end
        return 0;
    endfunction

    // Day count with the year starting in March, so the leap day falls last.
    function automatic int unsigned civil_to_jdn(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
        int unsigned c;
        int unsigned ya;
        if (m > 2) begin
            m = m - 3;
        end else begin
            m = m + 9;
            y = y - 1;
        end
        c = y / 100;
        ya = y - 100 * c;
        return JD_EPOCH + d + (146097 * c) / 4 + (1461 * ya) / 4 + (153 * m + 2) / 5;
    endfunction

    function automatic void jdn_to_civil(input int unsigned jd, output int unsigned y,
                                         output int unsigned m, output int unsigned d);
        int unsigned j;
        int unsigned c;
        int unsigned x;
        int unsigned yy;
        int unsigned mm;
        j = jd - JD_EPOCH;
        c = (4 * j - 1) / 146097;
        j = 4 * j - 146097 * c - 1;
        x = j / 4;
        j = (4 * x + 3) / 1461;
        yy = 100 * c + j;
        x = 4 * x + 3 - 1461 * j;
        x = (x + 4) / 4;
        mm = (5 * x - 3) / 153;
        x = 5 * x - 3 - 153 * mm;
        d = (x + 5) / 5;
        if (mm < 10) begin
            mm = mm + 3;
        end else begin
            mm = mm - 9;
            yy = yy + 1;
        end
        y = yy;
        m = mm;
    endfunction

    function automatic jdc_out_t predict_conversion(input logic cmd, input logic [13:0] yi,
                                                    input logic [3:0] mi, input logic [4:0] di,
                                                    input logic [22:0] ji);
        jdc_out_t    r;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned jd;
        bit          good;
        r = '0;
        y = yi;
        m = mi;
        d = di;
        jd = ji;
        if (cmd == CMD_TO_JD) begin
            // Two-digit years are folded into the 1900s before any range check.
            if (y <= TWO_DIGIT_MAX) begin
                y = y + YEAR_BASE;
            end
            good = (y >= YEAR_FIRST) && (y <= YEAR_LAST);
            if (y == YEAR_FIRST && (m < MON_FIRST || (m == MON_FIRST && d < DAY_FIRST))) begin
                good = 1'b0;
            end
            if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
                good = 1'b0;
            end
            if (good) begin
                jd = civil_to_jdn(y, m, d);
            end
        end else begin
            good = (ji >= JD_FIRST) && (ji <= JD_LAST);
            if (good) begin
                jdn_to_civil(jd, y, m, d);
            end
        end
        if (good) begin
            r.ok      = 1'b1;
            r.jd      = 23'(jd);
            r.year    = 14'(y);
            r.month   = 4'(m);
            r.day     = 5'(d);
            r.leap    = leap_year(y);
            r.weekday = 3'(jd % 7 + 1);
            r.ordinal = 9'(jd - civil_to_jdn(y, 1, 1) + 1);
            r.mlen    = 5'(days_in_month(y, m));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input longint unsigned got,
                                 input longint unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        jdc_out_t want;
        jdc_out_t got;
        if (!rst_n) begin
            expected_conversions.delete();
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.ok      = m_tuser;
                got.jd      = m_tdata[22:0];
                got.year    = m_tdata[36:23];
                got.month   = m_tdata[40:37];
                got.day     = m_tdata[45:41];
                got.leap    = m_tdata[46];
                got.weekday = m_tdata[49:47];
                got.ordinal = m_tdata[58:50];
                got.mlen    = m_tdata[63:59];
                if (expected_conversions.size() == 0) begin
                    report_mismatch("result item with no item pending");
                end else begin
                    want = expected_conversions.pop_front();
                    compare_field("valid_res", got.ok, want.ok);
                    compare_field("day_number_out", got.jd, want.jd);
                    compare_field("year_out", got.year, want.year);
                    compare_field("month_out", got.month, want.month);
                    compare_field("day_out", got.day, want.day);
                    compare_field("is_leap", got.leap, want.leap);
                    compare_field("weekday", got.weekday, want.weekday);
                    compare_field("ordinal_day", got.ordinal, want.ordinal);
                    compare_field("month_length", got.mlen, want.mlen);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_conversions.push_back(predict_conversion(s_tuser, s_tdata[13:0],
                    s_tdata[17:14], s_tdata[22:18], s_tdata[45:23]));
            end
            pending <= expected_conversions.size();
        end
    end

endmodule

// ----- tb/julian_day_calendar_converter_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the calendar converter testbench: clock, reset, item stimulus and
// receiver stalls. Depends on jdc_pkg, the converter core and the checker.
module julian_day_calendar_converter_core_tb;
    import jdc_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        hold_req;
    int          mismatches;
    int          pending;
    int          burst_left;
    int          cycle_count;

    julian_day_calendar_converter_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    jdc_conversion_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offers one item, inserting a random gap whenever the current burst runs out,
    // and returns at the edge where it is accepted.
    task automatic send_item(input logic cmd, input logic [13:0] y, input logic [3:0] m,
                             input logic [4:0] d, input logic [22:0] j);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            // One burst in four is long, so stretches without gaps occur too.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, j, d, m, y};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stops offering and waits until every pending result item has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: random stall patterns in stretches, plus one long hold-off on request.
    initial
    begin : receiver
        rx_mode_t mode;
        int       stretch;
        bit       hold_done;
        m_tready = 1'b0;
        mode = RX_ALWAYS;
        stretch = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                if (stretch == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    stretch = $urandom_range(10, 80);
                end
                stretch--;
                case (mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int          pick;
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [22:0] j;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Boundaries of the supported span, from the date side.
        send_item(CMD_TO_JD, 14'd1752, 4'd9, 5'd14, 23'd0);
        send_item(CMD_TO_JD, 14'd1752, 4'd9, 5'd13, 23'h7FFFFF);
        send_item(CMD_TO_JD, 14'd1752, 4'd8, 5'd31, 23'd0);
        send_item(CMD_TO_JD, 14'd1751, 4'd12, 5'd31, 23'd0);
        send_item(CMD_TO_JD, 14'd9999, 4'd12, 5'd31, 23'd0);
        send_item(CMD_TO_JD, 14'd10000, 4'd1, 5'd1, 23'd0);
        send_item(CMD_TO_JD, 14'h3FFF, 4'd1, 5'd1, 23'd0);
        // Two-digit years, and a small year that stays below the span.
        send_item(CMD_TO_JD, 14'd0, 4'd1, 5'd1, 23'd0);
        send_item(CMD_TO_JD, 14'd99, 4'd12, 5'd31, 23'd0);
        send_item(CMD_TO_JD, 14'd100, 4'd6, 5'd15, 23'd0);
        // Leap rules: 1900 is common, 2000 and 2004 are leap.
        send_item(CMD_TO_JD, 14'd0, 4'd2, 5'd29, 23'd0);
        send_item(CMD_TO_JD, 14'd2000, 4'd2, 5'd29, 23'd0);
        send_item(CMD_TO_JD, 14'd2004, 4'd2, 5'd29, 23'd0);
        // Bad month or day.
        send_item(CMD_TO_JD, 14'd2020, 4'd0, 5'd10, 23'd0);
        send_item(CMD_TO_JD, 14'd2020, 4'd13, 5'd10, 23'd0);
        send_item(CMD_TO_JD, 14'd2020, 4'd15, 5'd31, 23'd0);
        send_item(CMD_TO_JD, 14'd2020, 4'd5, 5'd0, 23'd0);
        send_item(CMD_TO_JD, 14'd2020, 4'd4, 5'd31, 23'd0);
        // Day numbers around and outside the span.
        send_item(CMD_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, JD_FIRST - 23'd1);
        send_item(CMD_TO_DATE, 14'd0, 4'd0, 5'd0, JD_FIRST);
        send_item(CMD_TO_DATE, 14'd0, 4'd0, 5'd0, JD_LAST);
        send_item(CMD_TO_DATE, 14'd0, 4'd0, 5'd0, JD_LAST + 23'd1);
        send_item(CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd0);
        send_item(CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'h7FFFFF);
        send_item(CMD_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd2451545);
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // The receiver holds off while items keep coming, so the pipeline fills.
            if (n == 300) begin
                hold_req <= 1'b1;
            end
            if (n == 700) begin
                wait_for_drain();
            end
            pick = $urandom_range(0, 99);
            y = 14'($urandom());
            m = 4'($urandom());
            d = 5'($urandom());
            j = 23'($urandom());
            if (pick < 40) begin
                // Well-formed dates, with years weighted toward the edges and leap rules.
                case ($urandom_range(0, 9))
                    0: y = 14'($urandom_range(0, 99));
                    1: begin
                        case ($urandom_range(0, 6))
                            0: y = 14'd1752;
                            1: y = 14'd1800;
                            2: y = 14'd1900;
                            3: y = 14'd2000;
                            4: y = 14'd2100;
                            5: y = 14'd2400;
                            default: y = 14'd9999;
                        endcase
                    end
                    default: y = 14'($urandom_range(YEAR_FIRST, YEAR_LAST));
                endcase
                m = 4'($urandom_range(1, 12));
                d = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(29, 31))
                                                : 5'($urandom_range(1, 28));
                send_item(CMD_TO_JD, y, m, d, j);
            end else if (pick < 75) begin
                case ($urandom_range(0, 9))
                    0: j = 23'($urandom_range(JD_FIRST - 3, JD_FIRST + 3));
                    1: j = 23'($urandom_range(JD_LAST - 3, JD_LAST + 3));
                    default: j = 23'($urandom_range(JD_FIRST, JD_LAST));
                endcase
                send_item(CMD_TO_DATE, y, m, d, j);
            end else begin
                send_item(1'($urandom()), y, m, d, j);
            end
        end
        wait_for_drain();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
